// File: rtl/core/u7e_pkg.sv
`default_nettype none

package u7e_pkg;

  // Most bytes that one input word can cause.
  localparam int unsigned BYTES_PER_PKT = 4;
  localparam int unsigned IDX_W = $clog2(BYTES_PER_PKT);

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_SET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT63    = 2'd2;

  // The bytes that one input word produces, in order, and the index of the final one.
  typedef struct packed {
    logic [IDX_W-1:0]                  last_idx;
    logic [BYTES_PER_PKT-1:0][6:0]     bytes;
  } pkt_t;

endpackage

`default_nettype wire

// File: rtl/core/u7e_front.sv
`default_nettype none

module u7e_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [u7e_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [u7e_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [15:0]                       s_tdata,
  input  wire logic                              s_tuser,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output u7e_pkg::pkt_t                          q_data
);

  localparam logic [6:0] CHAR_DASH = 7'h2d;
  localparam logic [6:0] CHAR_PLUS = 7'h2b;

  logic       direct_set_mode;
  logic [6:0] escape_char;
  logic [6:0] digit63_char;

  logic       in_base64;
  logic [1:0] digit_phase;
  logic [5:0] pending_bits;

  logic       in_base64_next;
  logic [1:0] digit_phase_next;
  logic [5:0] pending_bits_next;

  logic [2:0] n_bytes;
  logic       accept;
  logic       unit_direct;
  logic [15:0] ch;

  function automatic logic [6:0] digit_char(input logic [5:0] v, input logic [6:0] d63);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd97 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 7'd48 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = d63;
    end
    return r;
  endfunction

  function automatic logic is_direct(input logic [15:0] c, input logic mode);
    logic r;
    if (!mode) begin
      r = (c >= 16'h0020) && (c <= 16'h007e);
    end else begin
      r = ((c >= 16'd65) && (c <= 16'd90)) ||
          ((c >= 16'd97) && (c <= 16'd122)) ||
          ((c >= 16'd48) && (c <= 16'd57)) ||
          ((c >= 16'd39) && (c <= 16'd41)) ||
          ((c >= 16'd44) && (c <= 16'd47)) ||
          (c == 16'd9)  || (c == 16'd10) || (c == 16'd13) ||
          (c == 16'd32) || (c == 16'd33) || (c == 16'd34) ||
          ((c >= 16'd58) && (c <= 16'd63)) ||
          (c == 16'd91) || (c == 16'd93);
    end
    return r;
  endfunction

  assign ch          = s_tdata;
  assign s_tready    = !q_full;
  assign accept      = s_tvalid && s_tready;
  assign unit_direct = is_direct(ch, direct_set_mode);

  // The output bytes are appended one after another in the order they leave.
  always_comb begin
    q_data            = '0;
    n_bytes           = 3'd0;
    in_base64_next    = in_base64;
    digit_phase_next  = digit_phase;
    pending_bits_next = pending_bits;

    if (s_tuser || unit_direct) begin
      if (in_base64) begin
        if (digit_phase != 2'd0) begin
          q_data.bytes[n_bytes[1:0]] = digit_char(pending_bits, digit63_char);
          n_bytes = n_bytes + 3'd1;
        end
        q_data.bytes[n_bytes[1:0]] = CHAR_DASH;
        n_bytes = n_bytes + 3'd1;
        in_base64_next    = 1'b0;
        digit_phase_next  = 2'd0;
        pending_bits_next = 6'd0;
      end
      if (!s_tuser) begin
        q_data.bytes[n_bytes[1:0]] = ch[6:0];
        n_bytes = n_bytes + 3'd1;
        if (ch == {9'd0, escape_char}) begin
          q_data.bytes[n_bytes[1:0]] = CHAR_DASH;
          n_bytes = n_bytes + 3'd1;
        end
      end
    end else begin
      if (!in_base64) begin
        q_data.bytes[n_bytes[1:0]] = escape_char;
        n_bytes = n_bytes + 3'd1;
      end
      in_base64_next = 1'b1;
      unique case (digit_phase)
        2'd1: begin
          q_data.bytes[n_bytes[1:0]] =
            digit_char(pending_bits + {4'd0, ch[15:14]}, digit63_char);
          n_bytes = n_bytes + 3'd1;
          q_data.bytes[n_bytes[1:0]] = digit_char(ch[13:8], digit63_char);
          n_bytes = n_bytes + 3'd1;
          q_data.bytes[n_bytes[1:0]] = digit_char(ch[7:2], digit63_char);
          n_bytes = n_bytes + 3'd1;
          pending_bits_next = {ch[1:0], 4'd0};
          digit_phase_next  = 2'd2;
        end
        2'd2: begin
          q_data.bytes[n_bytes[1:0]] =
            digit_char(pending_bits + {2'd0, ch[15:12]}, digit63_char);
          n_bytes = n_bytes + 3'd1;
          q_data.bytes[n_bytes[1:0]] = digit_char(ch[11:6], digit63_char);
          n_bytes = n_bytes + 3'd1;
          q_data.bytes[n_bytes[1:0]] = digit_char(ch[5:0], digit63_char);
          n_bytes = n_bytes + 3'd1;
          pending_bits_next = 6'd0;
          digit_phase_next  = 2'd0;
        end
        default: begin
          // Phase three never arises and is treated like phase zero.
          q_data.bytes[n_bytes[1:0]] = digit_char(ch[15:10], digit63_char);
          n_bytes = n_bytes + 3'd1;
          q_data.bytes[n_bytes[1:0]] = digit_char(ch[9:4], digit63_char);
          n_bytes = n_bytes + 3'd1;
          pending_bits_next = {ch[3:0], 2'd0};
          digit_phase_next  = 2'd1;
        end
      endcase
    end

    q_data.last_idx = u7e_pkg::IDX_W'(n_bytes - 3'd1);
  end

  // A finish while already direct produces nothing and is not queued.
  assign q_push = accept && (n_bytes != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_set_mode <= 1'b1;
      escape_char     <= 7'd43;
      digit63_char    <= 7'd47;
      in_base64       <= 1'b0;
      digit_phase     <= 2'd0;
      pending_bits    <= 6'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          u7e_pkg::CFG_DIRECT_SET: direct_set_mode <= cfg_data[0];
          u7e_pkg::CFG_ESCAPE:     escape_char     <= cfg_data;
          u7e_pkg::CFG_DIGIT63:    digit63_char    <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        in_base64    <= in_base64_next;
        digit_phase  <= digit_phase_next;
        pending_bits <= pending_bits_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_only_in_base64: assert property (@(posedge clk) disable iff (rst)
    (digit_phase != 2'd0) |-> in_base64)
    else $error("digit phase set outside base64");

  a_no_phase_three: assert property (@(posedge clk) disable iff (rst)
    digit_phase != 2'd3)
    else $error("digit phase reached three");

  a_pending_zero_in_phase0: assert property (@(posedge clk) disable iff (rst)
    (digit_phase == 2'd0) |-> (pending_bits == 6'd0))
    else $error("pending bits left with phase zero");
`endif

endmodule

`default_nettype wire

// File: rtl/core/u7e_queue.sv
`default_nettype none

module u7e_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire u7e_pkg::pkt_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output u7e_pkg::pkt_t       head
);

  u7e_pkg::pkt_t mem [u7e_pkg::QUEUE_DEPTH];

  logic [u7e_pkg::QPTR_W-1:0] wr_ptr;
  logic [u7e_pkg::QPTR_W-1:0] rd_ptr;
  logic [u7e_pkg::QCNT_W-1:0] count;

  localparam logic [u7e_pkg::QPTR_W-1:0] PTR_LAST = u7e_pkg::QPTR_W'(u7e_pkg::QUEUE_DEPTH - 1);
  localparam logic [u7e_pkg::QCNT_W-1:0] CNT_FULL = u7e_pkg::QCNT_W'(u7e_pkg::QUEUE_DEPTH);

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/u7e_back.sv
`default_nettype none

module u7e_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire u7e_pkg::pkt_t  q_head,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);

  logic [u7e_pkg::IDX_W-1:0] idx;
  logic [6:0]                out_byte;
  logic                      load;
  logic                      final_byte;

  // The output register is refilled from the queue head whenever it is empty or being taken and the queue is not empty.
  assign load       = q_valid && (!m_tvalid || m_tready);
  assign final_byte = (idx == q_head.last_idx);
  assign q_pop      = load && final_byte;
  assign m_tdata    = {1'b0, out_byte};

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= q_head.bytes[idx];
      m_tlast  <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= final_byte ? '0 : idx + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_within_pkt: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (idx <= q_head.last_idx))
    else $error("byte index past end of packet");

  a_idx_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> (idx == '0))
    else $error("byte index not cleared between packets");
`endif

endmodule

`default_nettype wire

// File: rtl/core/utf16_to_utf7_encoder_unit.sv
`default_nettype none

// UTF-16 to UTF-7 encoder. Each input word carries a command in tuser (0 = encode the code
// unit in tdata, 1 = finish and return to direct mode) and produces one to four ASCII bytes
// on the output stream, tlast marking the final byte of each word; a finish while already
// direct produces nothing. The front part classifies a word and updates the base64 state in
// the cycle it is accepted, so it takes a word every cycle while the two-entry queue has room.
// The back part sends one byte per cycle while m_tready is high; a word causes 1 to 4 bytes.
// The first byte of a word is written into the queue, then loaded into the output register.
// Configuration (direct set, escape byte, character for digit 63) is written through
// cfg_we/cfg_index/cfg_data while the stream is idle; the user ensures it, the block does not.
module utf16_to_utf7_encoder_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [u7e_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [u7e_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,   // code_unit
  input  wire logic                           s_tuser,   // cmd
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [7:0]                          m_tdata,   // out_byte in bits 6:0, a zero bit on top
  output logic                                m_tlast
);

  u7e_pkg::pkt_t push_data;
  u7e_pkg::pkt_t head;
  logic          push;
  logic          full;
  logic          pop;
  logic          not_empty;

  u7e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  u7e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  u7e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_head   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// File: dv/tb_utf16_to_utf7_encoder_unit.sv
`timescale 1ns / 100ps

module tb_utf16_to_utf7_encoder_unit;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [6:0] CH_PLUS = 7'h2b;
  localparam logic [6:0] CH_DASH = 7'h2d;
  localparam logic [6:0] CH_SLASH = 7'h2f;

  // Cycles to let pass once the last expected byte is out.
  localparam int SETTLE_CYCLES = 8;
  localparam int WORDS_PER_PHASE = 36;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       last;
  } utf7_byte_t;

  typedef enum {ROW_PRED, ROW_FIXED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic                          cmd;
    logic [u7e_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                   value;
    string                         fix;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [u7e_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [u7e_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;   // code_unit
  logic s_tuser = 1'b0;        // cmd
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;         // out_byte in bits 6:0, a zero bit on top
  logic m_tlast;

  utf16_to_utf7_encoder_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #2 clk = ~clk;

  // Shadow of the encoder: configuration and base64 state.
  logic       direct_std = 1'b1;
  logic [6:0] escape_reg = 7'd43;
  logic [6:0] digit63_reg = 7'd47;
  logic       b64_active = 1'b0;
  logic [1:0] b64_phase = 2'd0;
  logic [5:0] b64_carry = 6'd0;

  logic [6:0] word_bytes[$];
  utf7_byte_t bytes_due[$];

  bit gaps_on = 1'b1;
  int err_count = 0;
  int words_sent = 0;
  int bytes_checked = 0;
  int settings_used = 1;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return 7'h41 + 7'(v);
    if (v < 6'd52) return 7'h61 + 7'(v - 6'd26);
    if (v < 6'd62) return 7'h30 + 7'(v - 6'd52);
    if (v == 6'd62) return CH_PLUS;
    return digit63_reg;
  endfunction

  function automatic bit is_direct_unit(input logic [15:0] c);
    if (!direct_std) return (c >= 16'h20) && (c <= 16'h7e);
    if (c >= 16'h41 && c <= 16'h5a) return 1'b1;
    if (c >= 16'h61 && c <= 16'h7a) return 1'b1;
    if (c >= 16'h30 && c <= 16'h39) return 1'b1;
    if (c >= 16'd39 && c <= 16'd41) return 1'b1;
    if (c >= 16'd44 && c <= 16'd47) return 1'b1;
    case (c)
      16'd9, 16'd10, 16'd13, 16'd32, 16'd33, 16'd34,
      16'd58, 16'd59, 16'd60, 16'd61, 16'd62, 16'd63,
      16'd91, 16'd93: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit(input logic [6:0] b);
    if (word_bytes.size() < u7e_pkg::BYTES_PER_PKT) word_bytes.push_back(b);
  endfunction

  function automatic void close_base64();
    if (!b64_active) return;
    if (b64_phase != 2'd0) emit(b64_char(b64_carry));
    emit(CH_DASH);
    b64_active = 1'b0;
    b64_phase = 2'd0;
    b64_carry = 6'd0;
  endfunction

  // Fills word_bytes with what one accepted word should produce.
  function automatic void encode_word(input logic c, input logic [15:0] u);
    word_bytes.delete();
    if (c == CMD_FINISH) begin
      close_base64();
    end else if (is_direct_unit(u)) begin
      close_base64();
      emit(u[6:0]);
      if (u == {9'd0, escape_reg}) emit(CH_DASH);
    end else begin
      if (!b64_active) begin
        emit(escape_reg);
        b64_active = 1'b1;
      end
      case (b64_phase)
        2'd1: begin
          emit(b64_char(6'(b64_carry + (u >> 14))));
          emit(b64_char(6'(u >> 8)));
          emit(b64_char(6'(u >> 2)));
          b64_carry = {u[1:0], 4'd0};
          b64_phase = 2'd2;
        end
        2'd2: begin
          emit(b64_char(6'(b64_carry + (u >> 12))));
          emit(b64_char(6'(u >> 6)));
          emit(b64_char(6'(u)));
          b64_carry = 6'd0;
          b64_phase = 2'd0;
        end
        default: begin
          emit(b64_char(6'(u >> 10)));
          emit(b64_char(6'(u >> 4)));
          b64_carry = {u[3:0], 2'd0};
          b64_phase = 2'd1;
        end
      endcase
    end
  endfunction

  function automatic dir_row_t w_row(input logic c, input logic [15:0] u);
    dir_row_t r;
    r.kind = ROW_PRED; r.cmd = c; r.idx = '0; r.value = u; r.fix = "";
    return r;
  endfunction

  function automatic dir_row_t f_row(input logic c, input logic [15:0] u, input string s);
    dir_row_t r;
    r.kind = ROW_FIXED; r.cmd = c; r.idx = '0; r.value = u; r.fix = s;
    return r;
  endfunction

  function automatic dir_row_t c_row(input logic [u7e_pkg::CFG_IDX_W-1:0] i,
                                     input logic [15:0] v);
    dir_row_t r;
    r.kind = ROW_CFG; r.cmd = CMD_ENCODE; r.idx = i; r.value = v; r.fix = "";
    return r;
  endfunction

  task automatic send_word(input logic c, input logic [15:0] u, input bit fixed,
                           input string fix);
    while (gaps_on && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= u;
    do @(posedge clk); while (!s_tready);
    encode_word(c, u);
    if (fixed) begin
      word_bytes.delete();
      for (int k = 0; k < fix.len(); k++) word_bytes.push_back(7'(fix[k]));
    end
    foreach (word_bytes[k])
      bytes_due.push_back('{out_byte: word_bytes[k], last: (k == word_bytes.size() - 1)});
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [u7e_pkg::CFG_IDX_W-1:0] i, input logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (i)
      u7e_pkg::CFG_DIRECT_SET: direct_std = v[0];
      u7e_pkg::CFG_ESCAPE:     escape_reg = v;
      u7e_pkg::CFG_DIGIT63:    digit63_reg = v;
      default: ;
    endcase
  endtask

  // Receiver: random back-pressure and the byte-by-byte comparison.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin : rx_check
        utf7_byte_t want;
        if (bytes_due.size() == 0) begin
          $error("unexpected byte %h (last %b)", m_tdata, m_tlast);
          err_count++;
        end else begin
          want = bytes_due.pop_front();
          bytes_checked++;
          if (m_tdata[6:0] !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, m_tdata[6:0]);
            err_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, m_tlast);
            err_count++;
          end
          if (m_tdata[7] !== 1'b0) begin
            $error("pad: expected 0, actual %b", m_tdata[7]);
            err_count++;
          end
        end
      end
      m_tready <= !gaps_on || ($urandom_range(99) >= 17);
    end
  end

  initial begin
    #400000;
    $display("Timed out with %0d bytes still awaited.", bytes_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[$];
    int burst;
    int r;
    int n;
    logic       p_mode;
    logic [6:0] p_esc;
    logic [6:0] p_d63;

    // Reset settings first: plus sign opens a run, slash is digit 63.
    dir_rows.push_back(f_row(CMD_FINISH, 16'h0000, ""));
    dir_rows.push_back(f_row(CMD_ENCODE, 16'h0041, "A"));
    dir_rows.push_back(f_row(CMD_ENCODE, 16'h0000, "+AA"));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'hffff));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'hffff));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'hffff));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h0041));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h00e9));
    dir_rows.push_back(w_row(CMD_FINISH, 16'hffff));
    dir_rows.push_back(f_row(CMD_FINISH, 16'h5a5a, ""));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h4e2d));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h6587));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h8a9e));
    dir_rows.push_back(w_row(CMD_FINISH, 16'h0000));
    dir_rows.push_back(f_row(CMD_ENCODE, 16'h0020, " "));
    dir_rows.push_back(f_row(CMD_ENCODE, 16'h0009, "\t"));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h007e));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h005c));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h007f));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h002b));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h005d));
    // A direct letter as the escape byte must be followed by a dash.
    dir_rows.push_back(c_row(u7e_pkg::CFG_ESCAPE, 16'h0041));
    dir_rows.push_back(f_row(CMD_ENCODE, 16'h0041, "A-"));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h8000));
    dir_rows.push_back(c_row(u7e_pkg::CFG_DIGIT63, 16'h007f));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'hffff));
    dir_rows.push_back(c_row(u7e_pkg::CFG_DIRECT_SET, 16'h0000));
    dir_rows.push_back(w_row(CMD_ENCODE, 16'h007e));
    dir_rows.push_back(f_row(CMD_ENCODE, 16'h0041, "A-"));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          write_reg(dir_rows[i].idx, dir_rows[i].value[6:0]);
          settings_used++;
        end
        ROW_FIXED: send_word(dir_rows[i].cmd, dir_rows[i].value, 1'b1, dir_rows[i].fix);
        default:   send_word(dir_rows[i].cmd, dir_rows[i].value, 1'b0, "");
      endcase
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin p_mode = 1'b1; p_esc = CH_PLUS; p_d63 = CH_SLASH; end
        1: begin p_mode = 1'b0; p_esc = CH_PLUS; p_d63 = CH_SLASH; end
        2: begin p_mode = 1'b1; p_esc = 7'h00;   p_d63 = 7'h7f; end
        3: begin p_mode = 1'b0; p_esc = 7'h7f;   p_d63 = 7'h00; end
        4: begin p_mode = 1'b0; p_esc = 7'h7e;   p_d63 = 7'($urandom_range(127)); end
        default: begin
          p_mode = 1'b1;
          p_esc = 7'($urandom_range(127));
          p_d63 = 7'($urandom_range(127));
        end
      endcase
      write_reg(u7e_pkg::CFG_DIRECT_SET, {6'd0, p_mode});
      write_reg(u7e_pkg::CFG_ESCAPE, p_esc);
      write_reg(u7e_pkg::CFG_DIGIT63, p_d63);
      settings_used++;
      gaps_on <= (ph != 1);
      n = 0;
      // Runs of random units, each ended by a finish, the escape byte or a random 7-bit unit.
      while (n < WORDS_PER_PHASE) begin
        burst = $urandom_range(6);
        repeat (burst) begin
          send_word(CMD_ENCODE, 16'($urandom), 1'b0, "");
          n++;
        end
        r = $urandom_range(99);
        if (r < 30)
          send_word(CMD_FINISH, 16'($urandom), 1'b0, "");
        else if (r < 50)
          send_word(CMD_ENCODE, {9'd0, escape_reg}, 1'b0, "");
        else
          send_word(CMD_ENCODE, 16'($urandom_range(127)), 1'b0, "");
        n++;
      end
    end

    drain();
    $display("Sent %0d words under %0d register settings; %0d output bytes compared.",
             words_sent, settings_used, bytes_checked);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found.", err_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
